>>> rtl/mgpe_pkg.sv
// shared types, constants and helpers of the mono glyph pixel expander
package mgpe_pkg;

	localparam int MAX_ROW_BYTES = 4;
	localparam int COL_W         = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int BYTE_PIXELS   = 8;
	localparam int BIT_W         = $clog2(BYTE_PIXELS);

	localparam int ADDR_W  = 32;
	localparam int COLOR_W = 32;
	localparam int LW_W    = 13;
	localparam int POS_W   = 12;
	localparam int RB_W    = 3;
	localparam int FONT_W  = 8;
	localparam int PROD_W  = LW_W + POS_W;

	localparam int IN_FIELDS_W = 2 * POS_W + RB_W + FONT_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ADDR_W + COLOR_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [FONT_W-1:0] LEFT_MASK = 8'h80;

	localparam logic [ADDR_W-1:0]  FRAME_BASE_RST = 32'h0000_0000;
	localparam logic [LW_W-1:0]    LINE_WIDTH_RST = 13'd800;
	localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 32'h00FF_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_BASE = 2'd0,
		CFG_LINE_WIDTH = 2'd1,
		CFG_DRAW_COLOR = 2'd2
	} cfg_index_t;

	// one non-empty bitmap byte ready for expansion
	typedef struct packed {
		logic [ADDR_W-1:0] row_addr;
		logic [COL_W-1:0]  col;
		logic [FONT_W-1:0] bits;
	} byte_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	function automatic logic [RB_W-1:0] eff_row_bytes(input logic [RB_W-1:0] raw);
		logic [RB_W-1:0] n;
		n = raw;
		if (n == '0) begin
			n = RB_W'(1);
		end
		if (int'(n) > MAX_ROW_BYTES) begin
			n = RB_W'(MAX_ROW_BYTES);
		end
		return n;
	endfunction

endpackage

>>> rtl/mgpe_front.sv
// front end: accepts bitmap bytes, tracks row address and column, queues byte jobs
module mgpe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [31:0]                frame_base,
	input  logic [12:0]                line_width,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [11:0]                glyph_x,
	input  logic [11:0]                glyph_y,
	input  logic [2:0]                 row_bytes,
	input  logic                       glyph_start,
	input  logic [7:0]                 font_byte,
	output logic                       push,
	output mgpe_pkg::byte_job_t        job,
	input  mgpe_pkg::fifo_status_t     fifo_status
);
	import mgpe_pkg::*;

	localparam int CMP_W = ((COL_W + 1) > RB_W) ? (COL_W + 1) : RB_W;

	logic              valid_s1;
	logic              start_s1;
	logic [RB_W-1:0]   rb_s1;
	logic [FONT_W-1:0] bits_s1;
	logic [ADDR_W-1:0] orig_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [ADDR_W-1:0] row_q;
	logic [COL_W-1:0]  col_q;
	logic              pend_q;

	logic              adv_s1;
	logic              accept;
	logic [ADDR_W-1:0] row_eff;
	logic [COL_W-1:0]  col_eff;
	logic [COL_W:0]    col_inc;
	logic              wrap;

	// an all-clear byte needs no queue slot; a pending stride add holds the stage
	assign adv_s1   = valid_s1 && !pend_q && (!fifo_status.full || bits_s1 == '0);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		row_eff = start_s1 ? (orig_s1 + ADDR_W'(prod_s1)) : row_q;
		col_eff = start_s1 ? '0 : col_q;
		col_inc = {1'b0, col_eff} + (COL_W + 1)'(1);
		wrap    = CMP_W'(col_inc) >= CMP_W'(rb_s1);
	end

	assign push         = adv_s1 && (bits_s1 != '0);
	assign job.row_addr = row_eff;
	assign job.col      = col_eff;
	assign job.bits     = bits_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= glyph_start;
			rb_s1    <= eff_row_bytes(row_bytes);
			bits_s1  <= font_byte;
			orig_s1  <= frame_base + ADDR_W'(glyph_x);
			prod_s1  <= PROD_W'(line_width) * PROD_W'(glyph_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			row_q  <= row_q + ADDR_W'(line_width);
			pend_q <= 1'b0;
		end else if (adv_s1) begin
			row_q  <= row_eff;
			col_q  <= wrap ? '0 : col_inc[COL_W-1:0];
			pend_q <= wrap;
		end
	end

endmodule

>>> rtl/mgpe_fifo.sv
// short queue of byte jobs between front end and pixel expander
module mgpe_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mgpe_pkg::byte_job_t     push_data,
	input  logic                    pop,
	output mgpe_pkg::byte_job_t     pop_data,
	output mgpe_pkg::fifo_status_t  status
);
	import mgpe_pkg::*;

	byte_job_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign status.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/mgpe_back.sv
// back end: expands one queued byte into pixel writes, leftmost set bit first
module mgpe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          draw_color,
	input  logic                 job_valid,
	input  mgpe_pkg::byte_job_t  job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          pixel_address,
	output logic [31:0]          pixel_value,
	output logic                 last_of_byte
);
	import mgpe_pkg::*;

	logic              work_valid_q;
	logic [ADDR_W-1:0] row_q;
	logic [COL_W-1:0]  col_q;
	logic [FONT_W-1:0] mask_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COLOR_W-1:0] value_q;
	logic              last_q;

	logic              emit;
	logic [BIT_W-1:0]  idx;
	logic [FONT_W-1:0] mask_next;
	logic              done;
	logic              free;

	// bit offset of the leftmost pixel still to draw
	always_comb begin
		idx = '0;
		for (int i = BYTE_PIXELS - 1; i >= 0; i--) begin
			if (mask_q[BYTE_PIXELS-1-i]) begin
				idx = BIT_W'(i);
			end
		end
	end

	assign mask_next = mask_q & ~(LEFT_MASK >> idx);
	assign done      = (mask_next == '0);
	assign emit      = work_valid_q && (!out_valid_q || out_ready);
	assign free      = !work_valid_q || (emit && done);
	assign pop       = free && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
		end else if (pop) begin
			work_valid_q <= 1'b1;
		end else if (emit && done) begin
			work_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q  <= job.row_addr;
			col_q  <= job.col;
			mask_q <= job.bits;
		end else if (emit) begin
			mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// column times eight plus bit offset is just the two concatenated
	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q  <= row_q + ADDR_W'({col_q, idx});
			value_q <= draw_color;
			last_q  <= done;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_value   = value_q;
	assign last_of_byte  = last_q;

endmodule

>>> rtl/mono_glyph_pixel_expander.sv
// top level of the mono glyph pixel expander: config registers, stream ports, assertions
//
// Turns 1-bit-per-pixel glyph bitmap bytes into framebuffer pixel writes. Each input beat
// carries one bitmap byte; tuser marks the first byte of a glyph, which reloads the row
// address from frame_base + glyph_x + line_width*glyph_y. Every set bit, leftmost first,
// gives one output beat with address, draw color, and tlast on the last write of the byte.
// An all-clear byte gives no output beat, and the output port is the limit. The front
// end can take a new byte while the last moves on, unless the queue is full, and holds
// after a byte that ends a glyph row, to add the line stride. A two-entry queue
// decouples the two, so the next bytes are taken while earlier pixels drain. The user
// must write configuration only while no byte is in flight; the block does not check.
module mono_glyph_pixel_expander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // glyph_x[11:0], glyph_y, row_bytes, font_byte, zero pad
	input  logic [0:0]  s_axis_tuser,  // glyph_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // pixel_address[31:0], pixel_value[63:32]
	output logic        m_axis_tlast
);
	import mgpe_pkg::*;

	logic [ADDR_W-1:0]  frame_base_q;
	logic [LW_W-1:0]    line_width_q;
	logic [COLOR_W-1:0] draw_color_q;

	logic [POS_W-1:0]  glyph_x;
	logic [POS_W-1:0]  glyph_y;
	logic [RB_W-1:0]   row_bytes;
	logic [FONT_W-1:0] font_byte;

	logic         push;
	logic         pop;
	byte_job_t    push_job;
	byte_job_t    head_job;
	fifo_status_t fifo_status;

	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= FRAME_BASE_RST;
			line_width_q <= LINE_WIDTH_RST;
			draw_color_q <= DRAW_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_BASE: frame_base_q <= cfg_data;
				CFG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				CFG_DRAW_COLOR: draw_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign glyph_x   = s_axis_tdata[POS_W-1:0];
	assign glyph_y   = s_axis_tdata[2*POS_W-1:POS_W];
	assign row_bytes = s_axis_tdata[2*POS_W+RB_W-1:2*POS_W];
	assign font_byte = s_axis_tdata[IN_FIELDS_W-1:2*POS_W+RB_W];

	mgpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_base  (frame_base_q),
		.line_width  (line_width_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.row_bytes   (row_bytes),
		.glyph_start (s_axis_tuser[0]),
		.font_byte   (font_byte),
		.push        (push),
		.job         (push_job),
		.fifo_status (fifo_status)
	);

	mgpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (head_job),
		.status    (fifo_status)
	);

	mgpe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.draw_color    (draw_color_q),
		.job_valid     (!fifo_status.empty),
		.job           (head_job),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last_of_byte  (m_axis_tlast)
	);

	assign m_axis_tdata = {pixel_value, pixel_address};

	// queue never overruns or underruns
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_status.full)
		else $error("byte job pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_status.empty)
		else $error("byte job popped from an empty queue");

	a_status_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_status.full && fifo_status.empty))
		else $error("queue reports full and empty at once");

	// an all-clear byte must never reach the expander
	a_job_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.bits != '0))
		else $error("empty bitmap byte queued");

endmodule

>>> verif/mgpe_pixel_checker.sv
// pixel write predictor and scoreboard for the mono glyph pixel expander
`timescale 1ns / 1ps

module mgpe_pixel_checker
	import mgpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          writes_owed
);

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_write_t;

	pixel_write_t pending_writes[$];

	logic [ADDR_W-1:0]  frame_base;
	logic [LW_W-1:0]    line_width;
	logic [COLOR_W-1:0] draw_color;
	logic [ADDR_W-1:0]  row_addr;
	int                 column;

	initial begin
		fail_count  = 0;
		writes_owed = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: pixel write mismatch on %s: got %h, want %h", $time, what, got, want);
		fail_count = fail_count + 1;
	endtask

	// expands one bitmap byte into the pixel writes it must cause, then steps the row state
	task automatic expand_byte(input logic [39:0] beat, input logic start);
		logic [POS_W-1:0]  gx;
		logic [POS_W-1:0]  gy;
		logic [RB_W-1:0]   rb_raw;
		logic [FONT_W-1:0] bits;
		logic [FONT_W-1:0] right_of;
		logic [ADDR_W-1:0] base;
		int                rb;
		pixel_write_t      w;
		gx     = beat[11:0];
		gy     = beat[23:12];
		rb_raw = beat[26:24];
		bits   = beat[34:27];
		if (rb_raw == '0) begin
			rb = 1;
		end else if (int'(rb_raw) > MAX_ROW_BYTES) begin
			rb = MAX_ROW_BYTES;
		end else begin
			rb = int'(rb_raw);
		end
		if (start) begin
			row_addr = frame_base + {20'b0, gx} + ({19'b0, line_width} * {20'b0, gy});
			column   = 0;
		end
		base = row_addr + 32'(column * BYTE_PIXELS);
		for (int i = 0; i < BYTE_PIXELS; i++) begin
			if ((bits & (LEFT_MASK >> i)) != '0) begin
				// last write when no set bit remains to the right
				right_of = (LEFT_MASK >> i) - 8'd1;
				w.addr   = base + 32'(i);
				w.color  = draw_color;
				w.last   = ((bits & right_of) == '0);
				pending_writes.push_back(w);
			end
		end
		column = column + 1;
		if (column >= rb) begin
			column   = 0;
			row_addr = row_addr + {19'b0, line_width};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_write_t want;
		if (!arst_n) begin
			frame_base = FRAME_BASE_RST;
			line_width = LINE_WIDTH_RST;
			draw_color = DRAW_COLOR_RST;
			row_addr   = '0;
			column     = 0;
			pending_writes.delete();
			writes_owed = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_writes.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata[31:0], '0);
				end else begin
					want = pending_writes.pop_front();
					if (m_tdata[31:0] !== want.addr) begin
						report_mismatch("pixel_address", m_tdata[31:0], want.addr);
					end
					if (m_tdata[63:32] !== want.color) begin
						report_mismatch("pixel_value", m_tdata[63:32], want.color);
					end
					if (m_tlast !== want.last) begin
						report_mismatch("last_of_byte", 32'(m_tlast), 32'(want.last));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_FRAME_BASE: begin
						frame_base = cfg_data;
					end
					CFG_LINE_WIDTH: begin
						line_width = cfg_data[LW_W-1:0];
					end
					CFG_DRAW_COLOR: begin
						draw_color = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				expand_byte(s_tdata, s_tuser[0]);
			end
			writes_owed = pending_writes.size();
		end
	end

endmodule

>>> verif/tb.sv
// stimulus, idling and verdict for the mono glyph pixel expander
`timescale 1ns / 1ps

module tb;
	import mgpe_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_TICKS = 20;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	cfg_index_t  cfg_index = CFG_FRAME_BASE;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	int fail_count;
	int writes_owed;
	int burst_left = 0;
	int beats_sent = 0;
	int idle_cycles = 0;
	logic hold_req = 1'b0;

	mono_glyph_pixel_expander DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.m_axis_tlast (m_tlast)
	);

	mgpe_pixel_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.writes_owed(writes_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random ready, its percentage redrawn from four choices, plus a long hold-off on request
	initial begin : receiver
		int ready_pct;
		int tick;
		ready_pct = 100;
		tick = 0;
		forever begin
			@(negedge clk);
			tick = tick + 1;
			if (tick % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 70;
					2: ready_pct = 30;
					default: ready_pct = 90;
				endcase
			end
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= ($urandom_range(0, 99) < ready_pct);
			end else begin
				m_tready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("[mono_glyph_pixel_expander] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// called and returns at a falling edge; bursts of beats with random gaps between them
	task automatic send_beat(input logic [11:0] gx, input logic [11:0] gy,
			input logic [2:0] rb, input logic start, input logic [7:0] font);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end
		s_tdata  <= {5'b0, font, rb, gy, gx};
		s_tuser  <= start;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left = burst_left - 1;
		beats_sent = beats_sent + 1;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (writes_owed != 0);
		// all-clear bytes may still be in flight without any write owed
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] base, input logic [12:0] stride,
			input logic [31:0] color);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FRAME_BASE;
		cfg_data  <= base;
		@(negedge clk);
		cfg_index <= CFG_LINE_WIDTH;
		cfg_data  <= (32'($urandom) & 32'hFFFF_E000) | {19'b0, stride};
		@(negedge clk);
		cfg_index <= CFG_DRAW_COLOR;
		cfg_data  <= color;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_glyph();
		logic [11:0] gx;
		logic [11:0] gy;
		logic [7:0]  font;
		int          rb;
		int          rows;
		gx   = 12'($urandom);
		gy   = 12'($urandom);
		rb   = $urandom_range(1, MAX_ROW_BYTES);
		rows = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < rb; c++) begin
				case ($urandom_range(0, 7))
					0: font = 8'h00;
					1: font = 8'hFF;
					default: font = 8'($urandom);
				endcase
				if (r == 0 && c == 0) begin
					send_beat(gx, gy, 3'(rb), 1'b1, font);
				end else begin
					// position fields are don't-care after the start beat
					send_beat(12'($urandom), 12'($urandom), 3'(rb), 1'b0, font);
				end
			end
		end
	endtask

	task automatic run_phase(input int n_beats, input int pause_at);
		int first;
		bit paused;
		first  = beats_sent;
		paused = 0;
		while (beats_sent - first < n_beats) begin
			if (!paused && pause_at > 0 && beats_sent - first >= pause_at) begin
				paused = 1;
				s_tvalid <= 1'b0;
				do @(negedge clk); while (writes_owed != 0);
			end
			if ($urandom_range(0, 99) < 80) begin
				send_glyph();
			end else begin
				send_beat(12'($urandom), 12'($urandom), 3'($urandom), 1'($urandom),
					8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values; first byte arrives with no glyph start since reset
		send_beat(12'hFFF, 12'hFFF, 3'd1, 1'b0, 8'hFF);
		send_beat(12'h000, 12'h000, 3'd1, 1'b1, 8'h80);
		// far corner, full four-byte row including an all-clear byte
		send_beat(12'hFFF, 12'hFFF, 3'd4, 1'b1, 8'h01);
		send_beat(12'h000, 12'h000, 3'd4, 1'b0, 8'hFF);
		send_beat(12'h000, 12'h000, 3'd4, 1'b0, 8'h00);
		send_beat(12'h000, 12'h000, 3'd4, 1'b0, 8'hA5);
		send_beat(12'h000, 12'h000, 3'd4, 1'b0, 8'h5A);
		// zero row bytes acts as one
		send_beat(12'd5, 12'd3, 3'd0, 1'b1, 8'h81);
		send_beat(12'd5, 12'd3, 3'd0, 1'b0, 8'h7E);
		// row bytes above the maximum saturate
		send_beat(12'd100, 12'd7, 3'd7, 1'b1, 8'h55);
		send_beat(12'd100, 12'd7, 3'd7, 1'b0, 8'hAA);
		send_beat(12'd100, 12'd7, 3'd5, 1'b0, 8'hFF);
		send_beat(12'd100, 12'd7, 3'd6, 1'b0, 8'h0F);
		send_beat(12'd100, 12'd7, 3'd7, 1'b0, 8'hF0);
		// row bytes shrinks mid-row past the current column
		send_beat(12'd40, 12'd9, 3'd4, 1'b1, 8'hC3);
		send_beat(12'd40, 12'd9, 3'd4, 1'b0, 8'h3C);
		send_beat(12'd40, 12'd9, 3'd1, 1'b0, 8'h18);
		send_beat(12'd40, 12'd9, 3'd1, 1'b0, 8'h01);
		wait_drained();

		// address wrap at the top of the range
		program_regs(32'hFFFF_FFFF, 13'd8191, 32'h0000_0000);
		send_beat(12'hFFF, 12'hFFF, 3'd2, 1'b1, 8'hFF);
		send_beat(12'hFFF, 12'hFFF, 3'd2, 1'b0, 8'hFF);
		send_beat(12'hFFF, 12'hFFF, 3'd2, 1'b0, 8'h00);
		send_beat(12'hFFF, 12'hFFF, 3'd2, 1'b0, 8'h80);
		run_phase(12, 0);
		wait_drained();

		// zero stride
		program_regs(32'h0000_0000, 13'd0, 32'hFFFF_FFFF);
		run_phase(15, 0);
		wait_drained();

		// the receiver holds off while the sender keeps offering beats
		program_regs($urandom, 13'd1, $urandom);
		hold_req = 1'b1;
		run_phase(22, 0);
		wait_drained();

		program_regs($urandom, 13'd4096, $urandom);
		run_phase(22, 11);
		wait_drained();

		program_regs($urandom, 13'($urandom_range(1, 4096)), $urandom);
		run_phase(22, 0);
		wait_drained();

		program_regs($urandom, 13'($urandom), $urandom);
		run_phase(22, 0);
		wait_drained();

		repeat (30) @(negedge clk);
		if (fail_count == 0 && writes_owed == 0) begin
			$display("[mono_glyph_pixel_expander] OK");
		end else begin
			$display("[mono_glyph_pixel_expander] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/mgpe_pkg.sv
rtl/mgpe_front.sv
rtl/mgpe_fifo.sv
rtl/mgpe_back.sv
rtl/mono_glyph_pixel_expander.sv
verif/mgpe_pixel_checker.sv
verif/tb.sv
